// ===== hw/rtl/ivm_pkg.sv =====
// ----------------------------------------------------------------------------
// ivm_pkg
// Shared types and codes for the interval value map: controller states,
// result status codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ivm_pkg;

  localparam int COUNT_BITS  = 5;
  localparam int STATUS_BITS = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_LK_RD,
    S_LK_EV,
    S_CP_RD,
    S_CP_EV,
    S_INS_B,
    S_INS_E,
    S_FIN,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;      // capture the input word
    logic    lk_start;  // start a value scan from the default
    logic    lk_take;   // take the entry just read, advance
    logic    cp_start;  // start the rebuild pass
    logic    cp_copy;   // copy the entry just read into the new bank
    logic    cp_skip;   // drop the entry just read
    logic    emit_b;    // write the range start breakpoint
    logic    emit_e;    // write the range end breakpoint
    logic    set_ins;   // range breakpoints are in place
    logic    commit;    // swap banks and take the new count
    logic    code_we;   // hold a status code for the result
    status_t code;
    logic    out_load;  // load the result word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic func;
    logic empty;      // reversed or empty range
    logic idx_end;    // scan index has reached the entry count
    logic rk_gt_tgt;  // entry key above the scan target
    logic rk_lt_kb;   // entry key below the range start
    logic rk_gt_ke;   // entry key above the range end
    logic v_ne_prev;  // new value differs from the value before the range
    logic end_ne_v;   // value at range end differs from the new value
    logic ins;
    logic full;       // rebuilt table overflows
    logic out_busy;   // result word still waiting
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ivm_ram.sv =====
// ----------------------------------------------------------------------------
// ivm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ivm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ivm_datapath.sv =====
// ----------------------------------------------------------------------------
// ivm_datapath
// Item registers, two-bank breakpoint table, scan and rebuild counters and
// the result word. The old bank is read while the new bank is written.
// ----------------------------------------------------------------------------
`default_nettype none

module ivm_datapath #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ivm_pkg::cmd_t             cmd,
  output ivm_pkg::stat_t                 stat,
  input  wire logic                      cfg_valid,
  input  wire logic [VALUE_BITS-1:0]     cfg_data,
  input  wire logic                      func,
  input  wire logic [KEY_BITS-1:0]       key_begin,
  input  wire logic [KEY_BITS-1:0]       key_end,
  input  wire logic [VALUE_BITS-1:0]     value,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [VALUE_BITS-1:0]          read_value,
  output logic [ivm_pkg::STATUS_BITS-1:0] status,
  output logic [ivm_pkg::COUNT_BITS-1:0]  entry_count
);

  import ivm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = $clog2(TABLE_DEPTH + 3);
  localparam int RD = 2 * (2 ** AW);

  logic                  func_r;
  logic [KEY_BITS-1:0]   kb;
  logic [KEY_BITS-1:0]   ke;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] dflt;
  logic [IW-1:0]         used;
  logic                  bank;
  logic [IW-1:0]         idx;
  logic [NW-1:0]         n;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] prev;
  logic                  ins;
  status_t               code_r;

  logic [KEY_BITS-1:0]   rk;
  logic [VALUE_BITS-1:0] rv;
  logic [KEY_BITS-1:0]   target;
  logic                  emit;
  logic                  we;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;
  logic [AW:0]           raddr;
  logic [AW:0]           waddr;

  // Default value register
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt <= '0;
    end else if (cfg_valid) begin
      dflt <= cfg_data;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      kb     <= key_begin;
      ke     <= key_end;
      val_r  <= value;
    end
  end

  // Scan and rebuild registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      bank <= 1'b0;
    end else if (cmd.commit) begin
      used <= IW'(n);
      bank <= ~bank;
    end
    if (cmd.lk_start || cmd.cp_start) begin
      idx <= '0;
    end else if (cmd.lk_take || cmd.cp_copy || cmd.cp_skip) begin
      idx <= IW'(idx + 1'b1);
    end
    if (cmd.lk_start) begin
      acc <= dflt;
    end else if (cmd.lk_take) begin
      acc <= rv;
    end
    if (cmd.cp_start) begin
      prev <= dflt;
    end else if (cmd.cp_copy) begin
      prev <= rv;
    end
    if (cmd.cp_start) begin
      n <= '0;
    end else if (emit) begin
      n <= NW'(n + 1'b1);
    end
    if (cmd.cp_start) begin
      ins <= 1'b0;
    end else if (cmd.set_ins) begin
      ins <= 1'b1;
    end
    if (cmd.code_we) begin
      code_r <= cmd.code;
    end
  end

  // Select the breakpoint to write into the new bank
  always_comb begin
    emit = cmd.cp_copy || cmd.emit_b || cmd.emit_e;
    wkey = rk;
    wval = rv;
    if (cmd.emit_b) begin
      wkey = kb;
      wval = val_r;
    end else if (cmd.emit_e) begin
      wkey = ke;
      wval = acc;
    end
  end

  assign we     = emit && (n < NW'(TABLE_DEPTH));
  assign waddr  = {~bank, n[AW-1:0]};
  assign raddr  = {bank, idx[AW-1:0]};
  assign target = func_r ? kb : ke;

  ivm_ram #(.WIDTH(KEY_BITS), .DEPTH(RD)) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rk)
  );

  ivm_ram #(.WIDTH(VALUE_BITS), .DEPTH(RD)) u_vals (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rv)
  );

  // Result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      read_value  <= func_r ? acc : '0;
      status      <= code_r;
      entry_count <= COUNT_BITS'(used);
    end
  end

  // Status back to the controller
  always_comb begin
    stat.func      = func_r;
    stat.empty     = kb >= ke;
    stat.idx_end   = idx == used;
    stat.rk_gt_tgt = rk > target;
    stat.rk_lt_kb  = rk < kb;
    stat.rk_gt_ke  = rk > ke;
    stat.v_ne_prev = val_r != prev;
    stat.end_ne_v  = acc != val_r;
    stat.ins       = ins;
    stat.full      = n > NW'(TABLE_DEPTH);
    stat.out_busy  = out_valid && !out_ready;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= IW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result word overwritten while waiting");

  a_commit_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> n <= NW'(TABLE_DEPTH))
    else $error("commit of an overflowing table");

endmodule

`default_nettype wire

// ===== hw/rtl/ivm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ivm_ctrl
// Sequencer for lookups and range assigns: value scan over the old bank,
// then, for an assign, a rebuild pass that streams entries into the new
// bank with the range breakpoints spliced in.
// ----------------------------------------------------------------------------
`default_nettype none

module ivm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ivm_pkg::stat_t stat,
  output ivm_pkg::cmd_t       cmd
);

  import ivm_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_DONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        cmd.code_we = 1'b1;
        if (!stat.func && stat.empty) begin
          cmd.code   = ST_EMPTY;
          state_next = S_OUT;
        end else begin
          cmd.lk_start = 1'b1;
          state_next   = S_LK_RD;
        end
      end
      S_LK_RD: begin
        if (stat.idx_end) begin
          if (stat.func) begin
            state_next = S_OUT;
          end else begin
            cmd.cp_start = 1'b1;
            state_next   = S_CP_RD;
          end
        end else begin
          state_next = S_LK_EV;
        end
      end
      S_LK_EV: begin
        if (stat.rk_gt_tgt) begin
          if (stat.func) begin
            state_next = S_OUT;
          end else begin
            cmd.cp_start = 1'b1;
            state_next   = S_CP_RD;
          end
        end else begin
          cmd.lk_take = 1'b1;
          state_next  = S_LK_RD;
        end
      end
      S_CP_RD: begin
        if (stat.idx_end) begin
          state_next = stat.ins ? S_FIN : S_INS_B;
        end else begin
          state_next = S_CP_EV;
        end
      end
      S_CP_EV: begin
        if (!stat.ins) begin
          if (stat.rk_lt_kb) begin
            cmd.cp_copy = 1'b1;
            state_next  = S_CP_RD;
          end else begin
            state_next = S_INS_B;
          end
        end else begin
          cmd.cp_copy = stat.rk_gt_ke;
          cmd.cp_skip = !stat.rk_gt_ke;
          state_next  = S_CP_RD;
        end
      end
      S_INS_B: begin
        cmd.emit_b = stat.v_ne_prev;
        state_next = S_INS_E;
      end
      S_INS_E: begin
        cmd.emit_e  = stat.end_ne_v;
        cmd.set_ins = 1'b1;
        state_next  = S_CP_RD;
      end
      S_FIN: begin
        cmd.code_we = 1'b1;
        cmd.code    = stat.full ? ST_FULL : ST_DONE;
        cmd.commit  = !stat.full;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHK)
    else $error("item taken outside idle");

  a_single_emit: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.cp_copy, cmd.emit_b, cmd.emit_e}) <= 1)
    else $error("two table writes in one cycle");

  a_out_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == S_IDLE)
    else $error("result load without return to idle");

endmodule

`default_nettype wire

// ===== hw/rtl/interval_value_map_core.sv =====
// ----------------------------------------------------------------------------
// interval_value_map_core
// Sorted breakpoint table mapping key ranges to values, with range assign
// and key lookup, one result word per input word.
// ----------------------------------------------------------------------------
// One word at a time. A lookup scans the entries at or below the key; a
// non-empty assign scans the entries at or below the range end, then
// rebuilds the whole table, reading each entry from the table RAM, which
// has a registered read, once in the end-value scan and once in the
// rebuild pass. The next word is taken as soon as the result word is
// loaded, while that result still waits for its consumer. No clearing pass after reset.
`default_nettype none

module interval_value_map_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [VALUE_BITS-1:0]      cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       func,
  input  wire logic [KEY_BITS-1:0]        key_begin,
  input  wire logic [KEY_BITS-1:0]        key_end,
  input  wire logic [VALUE_BITS-1:0]      value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [VALUE_BITS-1:0]           read_value,
  output logic [ivm_pkg::STATUS_BITS-1:0] status,
  output logic [ivm_pkg::COUNT_BITS-1:0]  entry_count
);

  import ivm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ivm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ivm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .func        (func),
    .key_begin   (key_begin),
    .key_end     (key_end),
    .value       (value),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire
